// ----- src/wfrs_pkg.sv -----
// ----------------------------------------------------------------------------
// wfrs_pkg: shared types and constants for the WAL frame recovery scanner
// Holds the item and result structs, verdict codes, layout sizes and the
// FNV-1a byte step used by the checker.
// ----------------------------------------------------------------------------
package wfrs_pkg;

  // Layout sizes in bytes.
  localparam int PAGE_BYTES       = 4096;
  localparam int FRAME_HEAD_BYTES = 24;
  localparam int LOG_HEAD_BYTES   = 32;
  localparam int FRAME_BYTES      = FRAME_HEAD_BYTES + PAGE_BYTES;
  localparam int POS_W = $clog2((FRAME_BYTES > LOG_HEAD_BYTES) ? FRAME_BYTES : LOG_HEAD_BYTES);

  // Page size as it appears in the header word.
  localparam logic [31:0] PAGE_SIZE_WORD = 32'(PAGE_BYTES);

  // FNV-1a 64-bit offset basis.
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  // Verdict codes.
  localparam logic [2:0] V_HEADER_OK   = 3'd0;
  localparam logic [2:0] V_NO_LOG      = 3'd1;
  localparam logic [2:0] V_FRAME_OK    = 3'd2;
  localparam logic [2:0] V_SALT_BAD    = 3'd3;
  localparam logic [2:0] V_SUM_BAD     = 3'd4;
  localparam logic [2:0] V_SUMMARY     = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_log;
  } item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] page_number;
    logic [31:0] frame_number;
    logic [31:0] commit_pages;
    logic [31:0] frames_committed;
    logic [63:0] commit_sum;
  } result_t;

  // Classified item passed from the front part to the back part.
  typedef struct packed {
    item_t            item;
    logic             hdr;
    logic             last;
    logic [POS_W-1:0] pos;
  } tag_t;

  // Magic string byte at a given index.
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h53;
      3'd1: b = 8'h51;
      3'd2: b = 8'h4C;
      3'd3: b = 8'h57;
      3'd4: b = 8'h41;
      3'd5: b = 8'h4C;
      3'd6: b = 8'h30;
      3'd7: b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One FNV-1a step; the prime 2^40 + 2^8 + 0xB3 is spelled as shift-adds.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ----- src/wfrs_front.sv -----
// ----------------------------------------------------------------------------
// wfrs_front: byte classifier
// Tracks the byte position within the header or the current frame and tags
// each transfer with it before it enters the queue.
// ----------------------------------------------------------------------------
module wfrs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  wfrs_pkg::item_t item,
  output logic           push,
  input  logic           push_ready,
  output wfrs_pkg::tag_t push_tag
);

  logic                      hdr;
  logic [wfrs_pkg::POS_W-1:0] pos;
  logic                      last;

  // The header and frames have fixed lengths, so the position alone tells
  // where each byte belongs.
  always_comb begin
    if (hdr) begin
      last = (pos == wfrs_pkg::POS_W'(wfrs_pkg::LOG_HEAD_BYTES - 1));
    end else begin
      last = (pos == wfrs_pkg::POS_W'(wfrs_pkg::FRAME_BYTES - 1));
    end
  end

  assign item_ready     = push_ready;
  assign push           = item_valid && push_ready;
  assign push_tag.item  = item;
  assign push_tag.hdr   = hdr;
  assign push_tag.last  = last;
  assign push_tag.pos   = pos;

  // Position counter; end of log restarts at the header.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr <= 1'b1;
      pos <= '0;
    end else if (push) begin
      if (item.end_of_log) begin
        hdr <= 1'b1;
        pos <= '0;
      end else if (last) begin
        hdr <= 1'b0;
        pos <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

// ----- src/wfrs_queue.sv -----
// ----------------------------------------------------------------------------
// wfrs_queue: two-entry queue of classified bytes
// Lets the classifier and the checker stall independently.
// ----------------------------------------------------------------------------
module wfrs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  wfrs_pkg::tag_t push_tag,
  output logic           pop_valid,
  input  logic           pop,
  output wfrs_pkg::tag_t pop_tag
);

  wfrs_pkg::tag_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_tag    = slots[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tag;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/wfrs_back.sv -----
// ----------------------------------------------------------------------------
// wfrs_back: header and frame checker
// Runs the FNV-1a chain one byte per cycle unless a held result stalls it,
// checks header and frame fields, tracks the last commit, registers results.
// ----------------------------------------------------------------------------
module wfrs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop,
  input  wfrs_pkg::tag_t   pop_tag,
  output logic             result_valid,
  input  logic             result_ready,
  output wfrs_pkg::result_t result
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_FRAMES = 2'd1;
  localparam logic [1:0] PH_DRAIN  = 2'd2;
  localparam logic [1:0] PH_DEAD   = 2'd3;

  logic [1:0]  phase;
  logic [63:0] running_sum;
  logic [63:0] saved_sum;
  logic [63:0] field_shift;
  logic        header_ok;
  logic [31:0] salt_first;
  logic [31:0] salt_second;
  logic [31:0] frame_page;
  logic [31:0] frame_commit;
  logic        salt_match;
  logic [31:0] frames_seen;
  logic [31:0] last_commit_frames;
  logic [31:0] last_commit_pages;

  logic [1:0]  phase_next;
  logic [63:0] running_sum_next;
  logic [63:0] saved_sum_next;
  logic [63:0] field_shift_next;
  logic        header_ok_next;
  logic [31:0] salt_first_next;
  logic [31:0] salt_second_next;
  logic [31:0] frame_page_next;
  logic [31:0] frame_commit_next;
  logic        salt_match_next;
  logic [31:0] frames_seen_next;
  logic [31:0] last_commit_frames_next;
  logic [31:0] last_commit_pages_next;
  logic        emit;
  wfrs_pkg::result_t emit_res;

  logic [7:0]                 b;
  logic [wfrs_pkg::POS_W-1:0] p;
  logic [63:0]                fnv;
  logic [7:0]                 expect_byte;

  assign b   = pop_tag.item.data_byte;
  assign p   = pop_tag.pos;
  assign fnv = wfrs_pkg::fnv_step(running_sum, b);

  // The checker advances unless the byte produces a result while the output
  // register still holds one that is not taken this cycle.
  assign pop = pop_valid && (!emit || !result_valid || result_ready);

  // Byte processing for the current classified byte.
  always_comb begin
    phase_next              = phase;
    running_sum_next        = running_sum;
    saved_sum_next          = saved_sum;
    field_shift_next        = field_shift;
    header_ok_next          = header_ok;
    salt_first_next         = salt_first;
    salt_second_next        = salt_second;
    frame_page_next         = frame_page;
    frame_commit_next       = frame_commit;
    salt_match_next         = salt_match;
    frames_seen_next        = frames_seen;
    last_commit_frames_next = last_commit_frames;
    last_commit_pages_next  = last_commit_pages;
    emit                    = 1'b0;
    emit_res                = '0;
    expect_byte             = 8'd0;

    if (pop_tag.item.end_of_log) begin
      // End of log: report unless the header failed, then return to the reset state.
      if (phase == PH_HEADER) begin
        emit             = 1'b1;
        emit_res.verdict = wfrs_pkg::V_NO_LOG;
      end else if (phase == PH_FRAMES || phase == PH_DRAIN) begin
        emit                      = 1'b1;
        emit_res.verdict          = wfrs_pkg::V_SUMMARY;
        emit_res.commit_pages     = last_commit_pages;
        emit_res.frames_committed = last_commit_frames;
        emit_res.commit_sum       = saved_sum;
      end
      phase_next              = PH_HEADER;
      running_sum_next        = wfrs_pkg::FNV_BASIS;
      saved_sum_next          = '0;
      field_shift_next        = '0;
      header_ok_next          = 1'b1;
      salt_first_next         = '0;
      salt_second_next        = '0;
      frame_page_next         = '0;
      frame_commit_next       = '0;
      salt_match_next         = 1'b1;
      frames_seen_next        = '0;
      last_commit_frames_next = '0;
      last_commit_pages_next  = '0;
    end else if (phase == PH_HEADER) begin
      // Header bytes: magic, version, page size, salts and stored sum.
      if (p < wfrs_pkg::POS_W'(24)) begin
        running_sum_next = fnv;
      end
      if (p < wfrs_pkg::POS_W'(8)) begin
        if (b != wfrs_pkg::magic_byte(p[2:0])) header_ok_next = 1'b0;
      end else if (p < wfrs_pkg::POS_W'(12)) begin
        expect_byte = (p[1:0] == 2'd0) ? 8'd1 : 8'd0;
        if (b != expect_byte) header_ok_next = 1'b0;
      end else if (p < wfrs_pkg::POS_W'(16)) begin
        expect_byte = wfrs_pkg::PAGE_SIZE_WORD[8*p[1:0] +: 8];
        if (b != expect_byte) header_ok_next = 1'b0;
      end else if (p < wfrs_pkg::POS_W'(20)) begin
        salt_first_next[8*p[1:0] +: 8] = b;
      end else if (p < wfrs_pkg::POS_W'(24)) begin
        salt_second_next[8*p[1:0] +: 8] = b;
      end else if (p < wfrs_pkg::POS_W'(32)) begin
        field_shift_next[8*p[2:0] +: 8] = b;
      end
      if (pop_tag.last) begin
        emit = 1'b1;
        if (header_ok_next && field_shift_next == running_sum_next) begin
          running_sum_next    = field_shift_next;
          saved_sum_next      = field_shift_next;
          phase_next          = PH_FRAMES;
          emit_res.verdict    = wfrs_pkg::V_HEADER_OK;
          emit_res.commit_sum = field_shift_next;
        end else begin
          phase_next       = PH_DEAD;
          emit_res.verdict = wfrs_pkg::V_NO_LOG;
        end
      end
    end else if (phase == PH_FRAMES) begin
      // Frame bytes: header fields, salt check and chained sum.
      if (p == '0) begin
        salt_match_next = 1'b1;
      end
      if (p < wfrs_pkg::POS_W'(16) ||
          p >= wfrs_pkg::POS_W'(wfrs_pkg::FRAME_HEAD_BYTES)) begin
        running_sum_next = fnv;
      end
      if (p < wfrs_pkg::POS_W'(4)) begin
        frame_page_next[8*p[1:0] +: 8] = b;
      end else if (p < wfrs_pkg::POS_W'(8)) begin
        frame_commit_next[8*p[1:0] +: 8] = b;
      end else if (p < wfrs_pkg::POS_W'(12)) begin
        if (b != salt_first[8*p[1:0] +: 8]) salt_match_next = 1'b0;
      end else if (p < wfrs_pkg::POS_W'(16)) begin
        if (b != salt_second[8*p[1:0] +: 8]) salt_match_next = 1'b0;
      end else if (p < wfrs_pkg::POS_W'(24)) begin
        field_shift_next[8*p[2:0] +: 8] = b;
      end
      if (pop_tag.last) begin
        emit = 1'b1;
        if (!salt_match_next || field_shift_next != running_sum_next) begin
          phase_next                = PH_DRAIN;
          emit_res.verdict          = salt_match_next ? wfrs_pkg::V_SUM_BAD
                                                      : wfrs_pkg::V_SALT_BAD;
          emit_res.page_number      = frame_page_next;
          emit_res.frame_number     = frames_seen;
          emit_res.commit_pages     = frame_commit_next;
          emit_res.frames_committed = last_commit_frames;
          emit_res.commit_sum       = saved_sum;
        end else begin
          if (frames_seen != 32'hFFFF_FFFF) begin
            frames_seen_next = frames_seen + 32'd1;
          end
          if (frame_commit_next != 32'd0) begin
            last_commit_frames_next = frames_seen_next;
            saved_sum_next          = running_sum_next;
            last_commit_pages_next  = frame_commit_next;
          end
          emit_res.verdict          = wfrs_pkg::V_FRAME_OK;
          emit_res.page_number      = frame_page_next;
          emit_res.frame_number     = frames_seen;
          emit_res.commit_pages     = frame_commit_next;
          emit_res.frames_committed = last_commit_frames_next;
          emit_res.commit_sum       = saved_sum_next;
        end
      end
    end
  end

  // Checker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      running_sum        <= wfrs_pkg::FNV_BASIS;
      saved_sum          <= '0;
      field_shift        <= '0;
      header_ok          <= 1'b1;
      salt_first         <= '0;
      salt_second        <= '0;
      frame_page         <= '0;
      frame_commit       <= '0;
      salt_match         <= 1'b1;
      frames_seen        <= '0;
      last_commit_frames <= '0;
      last_commit_pages  <= '0;
    end else if (pop) begin
      phase              <= phase_next;
      running_sum        <= running_sum_next;
      saved_sum          <= saved_sum_next;
      field_shift        <= field_shift_next;
      header_ok          <= header_ok_next;
      salt_first         <= salt_first_next;
      salt_second        <= salt_second_next;
      frame_page         <= frame_page_next;
      frame_commit       <= frame_commit_next;
      salt_match         <= salt_match_next;
      frames_seen        <= frames_seen_next;
      last_commit_frames <= last_commit_frames_next;
      last_commit_pages  <= last_commit_pages_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      result <= emit_res;
    end
  end

endmodule

// ----- src/wal_frame_recovery_scanner_top.sv -----
// ----------------------------------------------------------------------------
// wal_frame_recovery_scanner_top: write-ahead log recovery scanner
// Checks a log byte stream: header, salted frames and a chained FNV-1a sum.
// ----------------------------------------------------------------------------
// The block takes one log byte per cycle while no waiting result stalls the
// checker; the limit is the FNV-1a step on the running sum, built as a
// handful of shift-adds. A byte reaches the checker through a two-entry
// queue, and a result appears in the output register the cycle after its
// last byte is checked. Results are one per completed header, checked frame,
// or end of log unless the header already failed; the output register lets
// new bytes be taken while a result waits.
module wal_frame_recovery_scanner_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  wfrs_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output wfrs_pkg::result_t result
);

  logic           push;
  logic           push_ready;
  wfrs_pkg::tag_t push_tag;
  logic           pop_valid;
  logic           pop;
  wfrs_pkg::tag_t pop_tag;

  // Classifier.
  wfrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (push),
    .push_ready (push_ready),
    .push_tag   (push_tag)
  );

  // Decoupling queue.
  wfrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_tag   (push_tag),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_tag    (pop_tag)
  );

  // Checker.
  wfrs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop          (pop),
    .pop_tag      (pop_tag),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- test/wal_frame_recovery_scanner_top_tb.sv -----
// ----------------------------------------------------------------------------
// wal_frame_recovery_scanner_top_tb: self-checking bench for the WAL scanner
// Builds whole logs byte by byte (good, corrupted, truncated and pure noise),
// feeds them through the item channel with random gaps, predicts every result
// in a scoreboard class and compares it field by field on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wal_frame_recovery_scanner_top_tb;

  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
  localparam logic [63:0] LOG_MAGIC = "SQLWAL01";
  localparam logic [31:0] PAGE_WORD = wfrs_pkg::PAGE_SIZE_WORD;

  typedef enum logic [1:0] {
    SCAN_HEADER,
    SCAN_FRAMES,
    SCAN_DRAIN,
    SCAN_DEAD
  } scan_phase_e;

  // One FNV-1a step on a 64-bit sum.
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_PRIME;
  endfunction

  // Scoreboard: tracks the scanner state and holds the verdicts still due.
  class wal_scoreboard;
    wfrs_pkg::result_t verdict_q[$];
    int          errors;
    scan_phase_e phase;
    int unsigned pos;
    logic [63:0] run_sum, saved_sum, stored_sum;
    bit          head_good, salts_good;
    logic [31:0] salt_a, salt_b, fpage, fcommit, seen, lc_frames, lc_pages;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = SCAN_HEADER;
      pos = 0;
      run_sum = wfrs_pkg::FNV_BASIS;
      saved_sum = '0;
      stored_sum = '0;
      head_good = 1;
      salts_good = 1;
      salt_a = '0;
      salt_b = '0;
      fpage = '0;
      fcommit = '0;
      seen = '0;
      lc_frames = '0;
      lc_pages = '0;
    endfunction

    // Advance the predicted state by one accepted item transfer.
    function void note(wfrs_pkg::item_t it);
      wfrs_pkg::result_t r;
      bit          got;
      int          sh;
      logic [7:0]  b;
      logic [31:0] idx;
      r = '0;
      got = 0;
      b = it.data_byte;
      sh = 8 * (pos % 4);
      if (it.end_of_log) begin
        if (phase == SCAN_HEADER) begin
          r.verdict = wfrs_pkg::V_NO_LOG;
          got = 1;
        end else if (phase == SCAN_FRAMES || phase == SCAN_DRAIN) begin
          r.verdict = wfrs_pkg::V_SUMMARY;
          r.commit_pages = lc_pages;
          r.frames_committed = lc_frames;
          r.commit_sum = saved_sum;
          got = 1;
        end
        clear();
      end else if (phase == SCAN_HEADER) begin
        if (pos < 24) run_sum = fnv_mix(run_sum, b);
        if (pos < 8) begin
          if (b != LOG_MAGIC[8 * (7 - pos) +: 8]) head_good = 0;
        end else if (pos < 12) begin
          if (b != ((pos == 8) ? 8'd1 : 8'd0)) head_good = 0;
        end else if (pos < 16) begin
          if (b != PAGE_WORD[sh +: 8]) head_good = 0;
        end else if (pos < 20) begin
          salt_a[sh +: 8] = b;
        end else if (pos < 24) begin
          salt_b[sh +: 8] = b;
        end else if (pos < 32) begin
          stored_sum[8 * (pos - 24) +: 8] = b;
        end
        pos++;
        if (pos == wfrs_pkg::LOG_HEAD_BYTES) begin
          pos = 0;
          got = 1;
          if (head_good && stored_sum == run_sum) begin
            saved_sum = stored_sum;
            phase = SCAN_FRAMES;
            r.verdict = wfrs_pkg::V_HEADER_OK;
            r.commit_sum = saved_sum;
          end else begin
            phase = SCAN_DEAD;
            r.verdict = wfrs_pkg::V_NO_LOG;
          end
        end
      end else if (phase == SCAN_FRAMES) begin
        if (pos == 0) begin
          fpage = '0;
          fcommit = '0;
          stored_sum = '0;
          salts_good = 1;
        end
        if (pos < 16 || pos >= wfrs_pkg::FRAME_HEAD_BYTES) run_sum = fnv_mix(run_sum, b);
        if (pos < 4) fpage[sh +: 8] = b;
        else if (pos < 8) fcommit[sh +: 8] = b;
        else if (pos < 12) begin
          if (b != salt_a[sh +: 8]) salts_good = 0;
        end else if (pos < 16) begin
          if (b != salt_b[sh +: 8]) salts_good = 0;
        end else if (pos < 24) stored_sum[8 * (pos - 16) +: 8] = b;
        pos++;
        if (pos == wfrs_pkg::FRAME_BYTES) begin
          pos = 0;
          got = 1;
          r.page_number = fpage;
          r.frame_number = seen;
          r.commit_pages = fcommit;
          if (!salts_good || stored_sum != run_sum) begin
            r.verdict = salts_good ? wfrs_pkg::V_SUM_BAD : wfrs_pkg::V_SALT_BAD;
            r.frames_committed = lc_frames;
            r.commit_sum = saved_sum;
            phase = SCAN_DRAIN;
          end else begin
            idx = seen;
            if (seen != 32'hFFFF_FFFF) seen++;
            if (fcommit != 0) begin
              lc_frames = seen;
              saved_sum = run_sum;
              lc_pages = fcommit;
            end
            r.verdict = wfrs_pkg::V_FRAME_OK;
            r.frame_number = idx;
            r.frames_committed = lc_frames;
            r.commit_sum = saved_sum;
          end
        end
      end
      if (got) verdict_q.push_back(r);
    endfunction

    // Compare one result transfer against the oldest prediction.
    function void check(wfrs_pkg::result_t r);
      wfrs_pkg::result_t e;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $realtime, r);
        errors++;
        return;
      end
      e = verdict_q.pop_front();
      if (r.verdict != e.verdict) begin
        $display("%0t: verdict expected %0d actual %0d", $realtime, e.verdict, r.verdict);
        errors++;
      end
      if (r.page_number != e.page_number) begin
        $display("%0t: page_number expected %h actual %h", $realtime, e.page_number,
                 r.page_number);
        errors++;
      end
      if (r.frame_number != e.frame_number) begin
        $display("%0t: frame_number expected %h actual %h", $realtime, e.frame_number,
                 r.frame_number);
        errors++;
      end
      if (r.commit_pages != e.commit_pages) begin
        $display("%0t: commit_pages expected %h actual %h", $realtime, e.commit_pages,
                 r.commit_pages);
        errors++;
      end
      if (r.frames_committed != e.frames_committed) begin
        $display("%0t: frames_committed expected %h actual %h", $realtime,
                 e.frames_committed, r.frames_committed);
        errors++;
      end
      if (r.commit_sum != e.commit_sum) begin
        $display("%0t: commit_sum expected %h actual %h", $realtime, e.commit_sum,
                 r.commit_sum);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  wfrs_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  wfrs_pkg::result_t result;

  wal_scoreboard sb;
  logic [7:0]    log_q[$];
  int            items_sent;
  bit            busy_mode;

  wal_frame_recovery_scanner_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    if (busy_mode || $urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  // Record accepted transfers on both channels.
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) sb.note(item);
    if (!rst && result_valid && result_ready) sb.check(result);
  end

  // Result side back-pressure.
  initial begin
    int n;
    result_ready = 1'b0;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Present one item and hold it until the transfer happens.
  task automatic send_item(input logic [7:0] b, input logic eol);
    int n;
    n = idle_len();
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    item <= '{data_byte: b, end_of_log: eol};
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) log_q.push_back(w[8 * i +: 8]);
  endtask

  // Random commit count: often zero, sometimes the extremes.
  function automatic logic [31:0] pick_commit();
    case ($urandom_range(0, 5))
      0, 1, 2: return '0;
      3: return 32'hFFFF_FFFF;
      4: return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // Build a well-formed log of nframes frames into log_q.
  task automatic build_log(input int nframes);
    logic [63:0] chain;
    logic [7:0]  head[$];
    logic [7:0]  page[];
    logic [63:0] s;
    logic [31:0] sa, sb2;
    log_q.delete();
    sa = $urandom();
    sb2 = $urandom();
    for (int i = 0; i < 8; i++) log_q.push_back(LOG_MAGIC[8 * (7 - i) +: 8]);
    push_word(32'd1);
    push_word(PAGE_WORD);
    push_word(sa);
    push_word(sb2);
    chain = wfrs_pkg::FNV_BASIS;
    foreach (log_q[i]) chain = fnv_mix(chain, log_q[i]);
    for (int i = 0; i < 8; i++) log_q.push_back(chain[8 * i +: 8]);
    for (int i = 32; i < wfrs_pkg::LOG_HEAD_BYTES; i++) log_q.push_back(8'($urandom()));
    page = new[wfrs_pkg::PAGE_BYTES];
    for (int f = 0; f < nframes; f++) begin
      head.delete();
      s = 64'($urandom());
      for (int i = 0; i < 4; i++) head.push_back(s[8 * i +: 8]);
      s = 64'(pick_commit());
      for (int i = 0; i < 4; i++) head.push_back(s[8 * i +: 8]);
      for (int i = 0; i < 4; i++) head.push_back(sa[8 * i +: 8]);
      for (int i = 0; i < 4; i++) head.push_back(sb2[8 * i +: 8]);
      foreach (head[i]) chain = fnv_mix(chain, head[i]);
      foreach (page[i]) begin
        page[i] = 8'($urandom());
        chain = fnv_mix(chain, page[i]);
      end
      foreach (head[i]) log_q.push_back(head[i]);
      for (int i = 0; i < 8; i++) log_q.push_back(chain[8 * i +: 8]);
      for (int i = 24; i < wfrs_pkg::FRAME_HEAD_BYTES; i++) log_q.push_back(8'($urandom()));
      foreach (page[i]) log_q.push_back(page[i]);
    end
  endtask

  // Send a log: flip bits at one position if asked, cut it if asked, then end it.
  task automatic run_log(input int nframes, input int flip_at, input logic [7:0] flip,
                         input int keep);
    build_log(nframes);
    if (flip_at >= 0 && flip_at < log_q.size()) log_q[flip_at] ^= flip;
    if (keep >= 0) while (log_q.size() > keep) void'(log_q.pop_back());
    foreach (log_q[i]) send_item(log_q[i], 1'b0);
    send_item(8'($urandom()), 1'b1);
  endtask

  initial begin
    int start_count;
    sb = new();
    items_sent = 0;
    busy_mode = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty log, short header, bad magic, version, page size, sum.
    send_item(8'hFF, 1'b1);
    run_log(0, -1, 8'h00, 10);
    run_log(0, 3, 8'h80, -1);
    run_log(0, 8, 8'h01, -1);
    run_log(0, 13, 8'h01, -1);
    run_log(0, 30, 8'h40, -1);
    // Good log, salt mismatch, checksum mismatch, partial frame.
    run_log(1, -1, 8'h00, -1);
    run_log(1, wfrs_pkg::LOG_HEAD_BYTES + 9, 8'h10, -1);
    run_log(1, wfrs_pkg::LOG_HEAD_BYTES + 100, 8'h02, -1);
    run_log(1, -1, 8'h00, wfrs_pkg::LOG_HEAD_BYTES + 500);
    run_log(0, -1, 8'h00, -1);

    // Random short logs: broken headers, cut logs, noise and good headers.
    start_count = items_sent;
    while (items_sent - start_count < 2000) begin
      busy_mode = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2: run_log(0, $urandom_range(0, wfrs_pkg::LOG_HEAD_BYTES - 1),
                         8'(1 << $urandom_range(0, 7)), -1);
        3, 4: run_log(1, -1, 8'h00, $urandom_range(0, wfrs_pkg::LOG_HEAD_BYTES + 200));
        5: begin
          repeat ($urandom_range(1, 60)) send_item(8'($urandom()), 1'b0);
          send_item(8'($urandom()), 1'b1);
        end
        default: run_log(0, -1, 8'h00, -1);
      endcase
    end
    busy_mode = 0;
    item_valid <= 1'b0;

    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
